[rtl/mfrl_pkg.sv]
// Package for the message flood rate limiter: result codes, register
// indexes, reset values and the default history depth.
// No dependencies; imported by every module of the block.
package mfrl_pkg;

   // Default number of entries in the history ring.
   localparam int HISTORY_DEPTH_DEFAULT = 16;

   // Field widths.
   localparam int FRAME_W   = 32;
   localparam int VERDICT_W = 2;
   localparam int SECS_W    = 29;
   localparam int MAXMSG_W  = 5;
   localparam int WINDOW_W  = 16;
   localparam int WAIT_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Result codes.
   localparam logic [VERDICT_W-1:0] VERDICT_ALLOW  = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_LOCKED = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_FLOOD  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MESSAGES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SECS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_TENTHS  = 2'd2;

   // Register reset values.
   localparam logic [MAXMSG_W-1:0] MAXMSG_RESET = 5'd0;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd4;
   localparam logic [WAIT_W-1:0]   WAIT_RESET   = 16'd100;

   // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP10) >> RECIP10_SHIFT.
   localparam logic [FRAME_W-1:0] RECIP10       = 32'hCCCC_CCCD;
   localparam int                 RECIP10_SHIFT = 35;

endpackage

[rtl/mfrl_div10.sv]
// Divide-by-ten unit for the rate limiter: a 32-bit value times the
// reciprocal of ten, giving an exact truncated quotient. Uses mfrl_pkg.
module mfrl_div10
   import mfrl_pkg::*;
(
   input  logic [FRAME_W-1:0] dividend,
   output logic [SECS_W-1:0]  quotient
);

   logic [2*FRAME_W-1:0] product;

   // The product is exact for every 32-bit dividend; the caller registers it.
   assign product  = {{FRAME_W{1'b0}}, dividend} * {{FRAME_W{1'b0}}, RECIP10};
   assign quotient = product[RECIP10_SHIFT +: SECS_W];

endmodule

[rtl/message_flood_rate_limiter.sv]
// Message flood rate limiter, top level: history ring memory, decision
// pipeline and register file. Uses mfrl_pkg and mfrl_div10.
//
// Usage. Each request carries req_frame_now, the frame count (ten frames per
// second) at which a message is attempted. Each request gives exactly one
// response: rsp_verdict (allowed, refused while locked, refused and newly
// locked) and rsp_seconds_left. Both channels use valid/ready.
// Configuration is written through csr_wr_en/csr_index/csr_wdata while no
// request is in flight; max_messages of zero lets everything through.
// Throughput: one request per cycle, sustained while rsp_ready is high. The
// history ring is read at acceptance, ahead of the decision, for both
// possible head positions, so a request whose predecessor stores a frame in
// the same cycle still finds its slot; the newest stored frame is forwarded
// around the memory. A request passes through the memory read, the decision
// and the divide-by-ten into the output register.
// Reset: synchronous reset clears the pipeline, the ring head, the lock
// deadline, the per-entry valid bits of the ring (an entry not yet written
// reads as an empty slot) and the registers to their defaults. No clearing
// pass is needed, so requests are taken from the first cycle after reset.
// Stall: when rsp_ready is low the response holds and the pipeline keeps
// filling; req_ready falls only when all three stages are full.
module message_flood_rate_limiter
   import mfrl_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
)(
   input  logic                 clock,
   input  logic                 reset,
   // Request channel.
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [FRAME_W-1:0]   req_frame_now,
   // Response channel.
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VERDICT_W-1:0] rsp_verdict,
   output logic [SECS_W-1:0]    rsp_seconds_left,
   // Configuration write port.
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int LW = $clog2(HISTORY_DEPTH + 1);
   localparam int CW = (LW > MAXMSG_W) ? LW : MAXMSG_W;
   localparam int SW = HW + 2;
   localparam int WIN10_W = WINDOW_W + 4;
   localparam logic [HW-1:0] LAST_SLOT = HW'(HISTORY_DEPTH - 1);

   // Configuration registers.
   logic [MAXMSG_W-1:0] max_messages_ff;
   logic [WINDOW_W-1:0] window_seconds_ff;
   logic [WAIT_W-1:0]   wait_delay_ff;

   // Ring state.
   logic [FRAME_W-1:0]       hist_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] hist_vld_ff;
   logic [HW-1:0]            head_ff, head_in, head_next;
   logic [FRAME_W-1:0]       lock_ff, lock_in;

   // Stage 1: request with both candidate ring reads.
   logic               s1_vld_ff, s1_vld_in;
   logic [FRAME_W-1:0] s1_frame_ff;
   logic [FRAME_W-1:0] s1_rd_a_ff, s1_rd_b_ff;
   logic               s1_va_ff, s1_vb_ff;
   logic               s1_sel_ff, s1_fwd_ff;
   logic [FRAME_W-1:0] s1_fwd_data_ff;

   // Stage 2: decision, waiting for the divide.
   logic                 s2_vld_ff, s2_vld_in;
   logic [VERDICT_W-1:0] s2_verdict_ff, s2_verdict_in;
   logic [FRAME_W-1:0]   s2_dividend_ff, s2_dividend_in;

   // Output register.
   logic                 rsp_vld_ff, rsp_vld_in;
   logic [VERDICT_W-1:0] rsp_verdict_ff;
   logic [SECS_W-1:0]    rsp_secs_ff, secs_q;

   // Handshake chain.
   logic out_free, s2_fire, s2_ready, s1_fire, req_fire;

   // Address and decision terms.
   logic              limit_on;
   logic [CW-1:0]     mm_ext, lim_c;
   logic [LW-1:0]     lim;
   logic [SW-1:0]     slot_sum;
   logic [HW-1:0]     rd_addr_a, rd_addr_b;
   logic              rd_en;
   logic [FRAME_W-1:0] then_val, age;
   logic [WIN10_W-1:0] win10;
   logic              locked, flood, s1_adv;

   // ---------------------------------------------------------------
   // Handshake. Each stage moves on when the one after it is free or moving.
   // ---------------------------------------------------------------
   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign s2_fire   = s2_vld_ff && out_free;
   assign s2_ready  = !s2_vld_ff || out_free;
   assign s1_fire   = s1_vld_ff && s2_ready;
   assign req_ready = !s1_vld_ff || s2_ready;
   assign req_fire  = req_valid && req_ready;

   // ---------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         max_messages_ff   <= MAXMSG_RESET;
         window_seconds_ff <= WINDOW_RESET;
         wait_delay_ff     <= WAIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_MESSAGES: max_messages_ff   <= csr_wdata[MAXMSG_W-1:0];
            CSR_WINDOW_SECS:  window_seconds_ff <= csr_wdata[WINDOW_W-1:0];
            CSR_WAIT_TENTHS:  wait_delay_ff     <= csr_wdata[WAIT_W-1:0];
            default: begin
               // Unused index: the write is dropped.
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Read addresses. The limit saturates at the ring depth. Address A is the
   // slot limit-1 places behind the current head; address B is the same slot
   // for the case that the request now deciding advances the head.
   // ---------------------------------------------------------------
   assign limit_on = (max_messages_ff != '0);
   assign mm_ext   = CW'(max_messages_ff);
   assign lim_c    = (mm_ext > CW'(HISTORY_DEPTH)) ? CW'(HISTORY_DEPTH) : mm_ext;
   assign lim      = LW'(lim_c);

   assign slot_sum  = SW'(head_ff) + SW'(HISTORY_DEPTH + 1) - SW'(lim);
   assign rd_addr_a = (slot_sum >= SW'(HISTORY_DEPTH)) ?
                      HW'(slot_sum - SW'(HISTORY_DEPTH)) : HW'(slot_sum);
   assign rd_addr_b = (rd_addr_a == LAST_SLOT) ? '0 : rd_addr_a + 1'b1;
   assign rd_en     = req_fire && limit_on;

   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;

   // ---------------------------------------------------------------
   // Decision for the request in stage 1. Registers updated by the request
   // ahead of it are already current; only the ring read was issued early.
   // ---------------------------------------------------------------
   always_comb begin
      if (s1_fwd_ff) begin
         then_val = s1_fwd_data_ff;
      end else if (s1_sel_ff) begin
         then_val = s1_vb_ff ? s1_rd_b_ff : '0;
      end else begin
         then_val = s1_va_ff ? s1_rd_a_ff : '0;
      end
   end

   // floor(age / 10) < window is the same as age < 10 * window.
   assign win10  = (WIN10_W'(window_seconds_ff) << 3) + (WIN10_W'(window_seconds_ff) << 1);
   assign age    = s1_frame_ff - then_val;
   assign locked = (s1_frame_ff < lock_ff);
   assign flood  = (then_val != '0) && (age < FRAME_W'(win10));
   assign s1_adv = s1_fire && limit_on && !locked && !flood;

   always_comb begin
      s2_verdict_in  = VERDICT_ALLOW;
      s2_dividend_in = '0;
      lock_in        = lock_ff;
      head_in        = head_ff;
      if (limit_on) begin
         if (locked) begin
            s2_verdict_in  = VERDICT_LOCKED;
            s2_dividend_in = lock_ff - s1_frame_ff;
         end else if (flood) begin
            s2_verdict_in  = VERDICT_FLOOD;
            s2_dividend_in = FRAME_W'(wait_delay_ff);
            lock_in        = s1_frame_ff + FRAME_W'(wait_delay_ff);
         end else begin
            head_in = head_next;
         end
      end
   end

   // ---------------------------------------------------------------
   // History ring memory: one write port, two registered read ports.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         hist_mem[head_next] <= s1_frame_ff;
      end
      if (rd_en) begin
         s1_rd_a_ff <= hist_mem[rd_addr_a];
         s1_rd_b_ff <= hist_mem[rd_addr_b];
      end
   end

   // ---------------------------------------------------------------
   // Control state: valid bits, head, lock deadline and stage valids.
   // ---------------------------------------------------------------
   assign s1_vld_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_vld_ff);
   assign s2_vld_in  = s1_fire ? 1'b1 : (s2_fire ? 1'b0 : s2_vld_ff);
   assign rsp_vld_in = s2_fire ? 1'b1 : ((rsp_vld_ff && rsp_ready) ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         head_ff     <= '0;
         lock_ff     <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (s1_fire) begin
            head_ff <= head_in;
            lock_ff <= lock_in;
         end
         if (s1_adv) begin
            hist_vld_ff[head_next] <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage payloads. At acceptance the new request records whether the
   // request deciding in the same cycle moves the head, and when the limit
   // is one it takes that request's frame directly, since the memory write
   // lands too late for the read.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_frame_ff    <= req_frame_now;
         s1_va_ff       <= hist_vld_ff[rd_addr_a];
         s1_vb_ff       <= hist_vld_ff[rd_addr_b];
         s1_sel_ff      <= s1_adv;
         s1_fwd_ff      <= s1_adv && (lim == LW'(1));
         s1_fwd_data_ff <= s1_frame_ff;
      end
      if (s1_fire) begin
         s2_verdict_ff  <= s2_verdict_in;
         s2_dividend_ff <= s2_dividend_in;
      end
      if (s2_fire) begin
         rsp_verdict_ff <= s2_verdict_ff;
         rsp_secs_ff    <= secs_q;
      end
   end

   // Seconds are the stage-2 value divided by ten; zero for allowed requests.
   mfrl_div10 u_div10 (
      .dividend (s2_dividend_ff),
      .quotient (secs_q)
   );

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_seconds_left = rsp_secs_ff;

endmodule

[rtl/mfrl_checker.sv]
// Port-level checker for the message flood rate limiter, bound to the top
// level. Uses mfrl_pkg; sees only the top level's ports.
module mfrl_checker
   import mfrl_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [VERDICT_W-1:0] rsp_verdict,
   input logic [SECS_W-1:0]    rsp_seconds_left
);

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict)
         && $stable(rsp_seconds_left))
      else $error("response changed while stalled");

   // No response is pending in the cycle after reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // An allowed request reports no remaining time.
   a_allow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_ALLOW |-> rsp_seconds_left == '0)
      else $error("allowed response with nonzero seconds");

   // A new lock reports at most the longest configurable wait.
   a_flood_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_FLOOD |-> rsp_seconds_left <= SECS_W'(6553))
      else $error("new lock reports more than the longest wait");

endmodule

bind message_flood_rate_limiter mfrl_checker u_mfrl_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_verdict      (rsp_verdict),
   .rsp_seconds_left (rsp_seconds_left)
);
